// ===== hdl/ppd_pkg.sv =====
// Shared constants for the point to polyline distance block.
`default_nettype none

package ppd_pkg;

	// Bits of the multiplier consumed per cycle by the serial multipliers.
	localparam int DIGIT_BITS = 8;

	// Width of the running minimum of squared distances.
	localparam int SQ_BITS = 62;

	// Width of the distance word.
	localparam int DIST_BITS = 32;

	// Saturated squared distance, also the empty minimum.
	localparam logic [SQ_BITS-1:0] SQ_MAX = '1;

endpackage

`default_nettype wire

// ===== hdl/point_to_polyline_distance.sv =====
// Least distance from a query point to a streamed polyline.
//
// Input channel (in_valid / in_stall): one word per vertex. The query point
// is latched with the first vertex; last_vertex ends the polyline and yields
// one distance word; empty_line yields an all-ones word and ignores the rest.
// Output channel (out_valid / out_stall): one distance word per polyline,
// floor of the Euclidean distance in 1/256 m.
// The block works on one vertex at a time and holds in_stall high meanwhile.
// Each of the five multiply phases runs on the two serial multiplier lanes.
// A vertex that closes a segment runs the multipliers and, when the
// projection falls strictly inside the segment, the divider; without a
// division the multiply on the fraction is skipped as well. A vertex
// opening a polyline runs only the vertex square phase. The last vertex
// adds the square root. Reset clears the open polyline and the minimum and
// empties the output register. While the receiver stalls, the finished word
// waits in the output register; the next vertex is still taken, and a
// further result waits until that register is free.
`default_nettype none

module point_to_polyline_distance #(
	parameter int COORD_BITS  = 30,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [COORD_BITS-1:0]         query_x,
	input  logic signed [COORD_BITS-1:0]         query_y,
	input  logic signed [COORD_BITS-1:0]         vertex_x,
	input  logic signed [COORD_BITS-1:0]         vertex_y,
	input  logic                                 first_vertex,
	input  logic                                 last_vertex,
	input  logic                                 empty_line,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ppd_pkg::DIST_BITS-1:0]        distance
);
	import ppd_pkg::*;

	// Differences, their products and the saturation width
	localparam int MW  = (COORD_BITS + 2 > T_FRAC_BITS + 1) ? COORD_BITS + 2
		: T_FRAC_BITS + 1;
	localparam int PW  = 2 * MW;
	localparam int NW  = PW + 1;
	localparam int SW  = (NW > SQ_BITS) ? NW : SQ_BITS;
	localparam int EXT = MW - COORD_BITS;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_PREP = 10'b00_0000_0010,
		ST_L2   = 10'b00_0000_0100,
		ST_DOT  = 10'b00_0000_1000,
		ST_DIV  = 10'b00_0001_0000,
		ST_TMUL = 10'b00_0010_0000,
		ST_ESQ  = 10'b00_0100_0000,
		ST_VSQ  = 10'b00_1000_0000,
		ST_ROOT = 10'b01_0000_0000,
		ST_EMIT = 10'b10_0000_0000
	} state_t;

	function automatic logic [MW-1:0] sext(input logic [COORD_BITS-1:0] v);
		sext = {{EXT{v[COORD_BITS-1]}}, v};
	endfunction

	function automatic logic [MW-1:0] mag(input logic [MW-1:0] v);
		mag = v[MW-1] ? (~v + MW'(1)) : v;
	endfunction

	state_t                  state_q;
	logic                    start_q;
	logic [COORD_BITS-1:0]   point_x_q, point_y_q;
	logic [COORD_BITS-1:0]   prev_x_q, prev_y_q;
	logic [COORD_BITS-1:0]   vx_q, vy_q;
	logic                    last_q;
	logic                    seg_q;
	logic                    have_prev_q;
	logic [SQ_BITS-1:0]      best_q;
	logic [MW-1:0]           dx_q, dy_q, px_q, py_q, wx_q, wy_q, ex_q, ey_q;
	logic [NW-1:0]           l2_q;
	logic [DIST_BITS-1:0]    res_q;
	logic [DIST_BITS-1:0]    distance_q;
	logic                    out_valid_q;

	logic                    accept;
	logic [MW-1:0]           op_ax, op_bx, op_ay, op_by;
	logic [PW-1:0]           prod_x, prod_y;
	logic                    mul_done_x, mul_done_y, mul_done;
	logic [NW-1:0]           sq_sum;
	logic [SW-1:0]           sq_ext;
	logic [SQ_BITS-1:0]      sq_sat;
	logic [SQ_BITS-1:0]      best_min;
	logic [NW-1:0]           term_x, term_y;
	logic [NW:0]             dot;
	logic                    dot_le0, dot_ge;
	logic signed [NW-1:0]    tx, ty, offx, offy;
	logic [MW-1:0]           ex_t, ey_t;
	logic                    div_start, div_done;
	logic [T_FRAC_BITS-1:0]  t_frac;
	logic                    sqrt_start, sqrt_done;
	logic [DIST_BITS-1:0]    root;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign mul_done  = mul_done_x && mul_done_y;
	assign out_valid = out_valid_q;
	assign distance  = distance_q;

	// Pick multiplier operands for the phase in progress
	always_comb begin
		case (state_q)
			ST_L2: begin
				op_ax = mag(dx_q);  op_bx = mag(dx_q);
				op_ay = mag(dy_q);  op_by = mag(dy_q);
			end
			ST_DOT: begin
				op_ax = mag(px_q);  op_bx = mag(dx_q);
				op_ay = mag(py_q);  op_by = mag(dy_q);
			end
			ST_TMUL: begin
				op_ax = MW'(t_frac); op_bx = mag(dx_q);
				op_ay = MW'(t_frac); op_by = mag(dy_q);
			end
			ST_ESQ: begin
				op_ax = mag(ex_q);  op_bx = mag(ex_q);
				op_ay = mag(ey_q);  op_by = mag(ey_q);
			end
			default: begin
				op_ax = mag(wx_q);  op_bx = mag(wx_q);
				op_ay = mag(wy_q);  op_by = mag(wy_q);
			end
		endcase
	end

	ppd_mul #(.OP_BITS(MW)) u_mul_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.a       (op_ax),
		.b       (op_bx),
		.product (prod_x),
		.done    (mul_done_x)
	);

	ppd_mul #(.OP_BITS(MW)) u_mul_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.a       (op_ay),
		.b       (op_by),
		.product (prod_y),
		.done    (mul_done_y)
	);

	// Combine lane products: squared sum, dot product, clamped offsets
	always_comb begin
		sq_sum   = NW'(prod_x) + NW'(prod_y);
		sq_ext   = SW'(sq_sum);
		sq_sat   = (sq_ext > SW'(SQ_MAX)) ? SQ_MAX : sq_ext[SQ_BITS-1:0];
		best_min = (sq_sat < best_q) ? sq_sat : best_q;

		term_x  = (px_q[MW-1] ^ dx_q[MW-1]) ? (NW'(0) - NW'(prod_x)) : NW'(prod_x);
		term_y  = (py_q[MW-1] ^ dy_q[MW-1]) ? (NW'(0) - NW'(prod_y)) : NW'(prod_y);
		dot     = {term_x[NW-1], term_x} + {term_y[NW-1], term_y};
		dot_le0 = dot[NW] || (dot == '0);
		dot_ge  = dot[NW-1:0] >= l2_q;

		// Offsets along the segment, rounded toward minus infinity
		tx   = dx_q[MW-1] ? (NW'(0) - NW'(prod_x)) : NW'(prod_x);
		ty   = dy_q[MW-1] ? (NW'(0) - NW'(prod_y)) : NW'(prod_y);
		offx = tx >>> T_FRAC_BITS;
		offy = ty >>> T_FRAC_BITS;
		ex_t = px_q - offx[MW-1:0];
		ey_t = py_q - offy[MW-1:0];
	end

	// Divide only when the projection falls strictly inside the segment
	assign div_start  = (state_q == ST_DOT) && mul_done && !dot_le0 && !dot_ge;
	assign sqrt_start = (state_q == ST_VSQ) && mul_done && last_q;

	ppd_div #(.NUM_BITS(NW), .Q_BITS(T_FRAC_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (dot[NW-1:0]),
		.den      (l2_q),
		.quotient (t_frac),
		.done     (div_done)
	);

	ppd_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (best_min),
		.root   (root),
		.done   (sqrt_done)
	);

	// Sequence one vertex word through the phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			point_x_q   <= '0;
			point_y_q   <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_prev_q <= 1'b0;
			best_q      <= SQ_MAX;
			last_q      <= 1'b0;
			seg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Launch the next multiply phase
			start_q <= (state_q == ST_PREP)
				|| (mul_done && (state_q inside {ST_L2, ST_TMUL, ST_ESQ}))
				|| (mul_done && (state_q == ST_DOT) && (dot_le0 || dot_ge))
				|| (div_done && (state_q == ST_DIV));
			// Raise the word on emit, drop it once taken
			if ((state_q == ST_EMIT) && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (empty_line) begin
							have_prev_q <= 1'b0;
							best_q      <= SQ_MAX;
							state_q     <= ST_EMIT;
						end else begin
							last_q <= last_vertex;
							if (first_vertex || !have_prev_q) begin
								point_x_q <= query_x;
								point_y_q <= query_y;
								best_q    <= SQ_MAX;
								seg_q     <= 1'b0;
							end else begin
								seg_q <= 1'b1;
							end
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					prev_x_q    <= vx_q;
					prev_y_q    <= vy_q;
					have_prev_q <= 1'b1;
					state_q     <= seg_q ? ST_L2 : ST_VSQ;
				end
				ST_L2: begin
					if (mul_done) begin
						state_q <= ST_DOT;
					end
				end
				ST_DOT: begin
					if (mul_done) begin
						if (dot_le0 || dot_ge) begin
							state_q <= ST_ESQ;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_TMUL;
					end
				end
				ST_TMUL: begin
					if (mul_done) begin
						state_q <= ST_ESQ;
					end
				end
				ST_ESQ: begin
					if (mul_done) begin
						best_q  <= best_min;
						state_q <= ST_VSQ;
					end
				end
				ST_VSQ: begin
					if (mul_done) begin
						if (last_q) begin
							have_prev_q <= 1'b0;
							best_q      <= SQ_MAX;
							state_q     <= ST_ROOT;
						end else begin
							best_q  <= best_min;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ROOT: begin
					if (sqrt_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the datapath operands and the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			vx_q <= vertex_x;
			vy_q <= vertex_y;
		end
		if (accept && empty_line) begin
			res_q <= '1;
		end
		if (state_q == ST_PREP) begin
			dx_q <= sext(vx_q) - sext(prev_x_q);
			dy_q <= sext(vy_q) - sext(prev_y_q);
			px_q <= sext(point_x_q) - sext(prev_x_q);
			py_q <= sext(point_y_q) - sext(prev_y_q);
			wx_q <= sext(point_x_q) - sext(vx_q);
			wy_q <= sext(point_y_q) - sext(vy_q);
		end
		if (state_q == ST_L2 && mul_done) begin
			l2_q <= sq_sum;
		end
		// A zero-length segment gives a zero dot and takes the start point
		if (state_q == ST_DOT && mul_done) begin
			if (dot_le0) begin
				ex_q <= px_q;
				ey_q <= py_q;
			end else if (dot_ge) begin
				ex_q <= px_q - dx_q;
				ey_q <= py_q - dy_q;
			end
		end
		if (state_q == ST_TMUL && mul_done) begin
			ex_q <= ex_t;
			ey_q <= ey_t;
		end
		if (state_q == ST_ROOT && sqrt_done) begin
			res_q <= root;
		end
		if (state_q == ST_EMIT && (!out_valid_q || !out_stall)) begin
			distance_q <= res_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("distance word raised outside the emit phase");

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_PREP || state_q == ST_EMIT))
		else $error("accepted word did not start processing");

	a_prep_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREP) |=> have_prev_q && (state_q == ST_L2 || state_q == ST_VSQ))
		else $error("vertex preparation did not open the polyline");

	a_lanes_lock: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done_x == mul_done_y)
		else $error("multiplier lanes out of step");
`endif

endmodule

`default_nettype wire

// ===== hdl/ppd_mul.sv =====
// Digit-serial unsigned multiplier, one multiplier digit per cycle.
`default_nettype none

module ppd_mul #(
	parameter int OP_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [OP_BITS-1:0]     a,
	input  logic [OP_BITS-1:0]     b,
	output logic [2*OP_BITS-1:0]   product,
	output logic                   done
);
	import ppd_pkg::*;

	localparam int PROD_BITS = 2 * OP_BITS;
	localparam int NDIG      = (OP_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int PAD_BITS  = NDIG * DIGIT_BITS;
	localparam int CNT_BITS  = $clog2(NDIG + 1);

	logic [PROD_BITS-1:0]            mcand_q;
	logic [PROD_BITS-1:0]            acc_q;
	logic [PAD_BITS-1:0]             mplier_q;
	logic [CNT_BITS-1:0]             cnt_q;
	logic                            busy_q;
	logic                            done_q;
	logic [PROD_BITS+DIGIT_BITS-1:0] partial;

	// Partial product of the shifted multiplicand and the low digit
	assign partial = mcand_q * mplier_q[DIGIT_BITS-1:0];

	// Count digits, flag the cycle after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(NDIG - 1)) begin
					busy_q <= 1'b0;
				end
			end
			done_q <= !start && busy_q && (cnt_q == CNT_BITS'(NDIG - 1));
		end
	end

	// Shift operands one digit, accumulate the partial product
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= PROD_BITS'(a);
			mplier_q <= PAD_BITS'(b);
			acc_q    <= '0;
		end else if (busy_q) begin
			mcand_q  <= mcand_q << DIGIT_BITS;
			mplier_q <= mplier_q >> DIGIT_BITS;
			acc_q    <= acc_q + partial[PROD_BITS-1:0];
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule

`default_nettype wire

// ===== hdl/ppd_div.sv =====
// Bit-serial restoring divider for the fraction bits of the projection.
`default_nettype none

module ppd_div #(
	parameter int NUM_BITS = 65,
	parameter int Q_BITS   = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [NUM_BITS-1:0] den,
	output logic [Q_BITS-1:0]   quotient,
	output logic                done
);
	localparam int CNT_BITS = $clog2(Q_BITS + 1);

	logic [NUM_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0] den_q;
	logic [Q_BITS-1:0]   quo_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [NUM_BITS:0]   trial;
	logic [NUM_BITS:0]   diff;
	logic                fits;

	// Double the remainder and try the subtraction
	always_comb begin
		trial = {rem_q, 1'b0};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	// Count quotient bits, flag the cycle after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(Q_BITS - 1)) begin
					busy_q <= 1'b0;
				end
			end
			done_q <= !start && busy_q && (cnt_q == CNT_BITS'(Q_BITS - 1));
		end
	end

	// Shift one quotient bit in per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[NUM_BITS-1:0] : trial[NUM_BITS-1:0];
			quo_q <= {quo_q[Q_BITS-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// ===== hdl/ppd_sqrt.sv =====
// Serial integer square root, one result bit per cycle.
`default_nettype none

module ppd_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ppd_pkg::SQ_BITS-1:0]    value,
	output logic [ppd_pkg::DIST_BITS-1:0]  root,
	output logic                           done
);
	import ppd_pkg::*;

	logic [SQ_BITS-1:0] rad_q;
	logic [SQ_BITS-1:0] res_q;
	logic [SQ_BITS-1:0] bit_q;
	logic [SQ_BITS-1:0] trial;
	logic               busy_q;
	logic               done_q;

	assign trial = res_q + bit_q;

	// Run until the one-hot weight has passed bit zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
			end
			done_q <= !start && busy_q && bit_q[0];
		end
	end

	// Subtract the trial when it fits, shift the weight down two places
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= value;
			res_q <= '0;
			bit_q <= SQ_BITS'(1) << (SQ_BITS - 2);
		end else if (busy_q) begin
			if (rad_q >= trial) begin
				rad_q <= rad_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[DIST_BITS-1:0];
	assign done = done_q;

endmodule

`default_nettype wire
